/* design/evdf_pkg.sv */
// Shared types and constants for the event deframer and link tracker.
`default_nettype none
package evdf_pkg;

  typedef enum logic [3:0] {
    PH_HUNT = 4'b0001,
    PH_TYPE = 4'b0010,
    PH_LEN  = 4'b0100,
    PH_BODY = 4'b1000
  } evdf_phase_e;

  localparam logic [7:0] START_BYTE  = 8'h02;
  localparam logic [7:0] KIND_ONLINE = 8'h00;
  localparam logic [7:0] KIND_STATUS = 8'h02;
  localparam logic [7:0] KIND_OFF_A  = 8'h03;
  localparam logic [7:0] KIND_OFF_B  = 8'h05;
  localparam logic [7:0] KIND_ACK    = 8'h06;
  localparam logic [7:0] KIND_SPP    = 8'h07;
  localparam logic [7:0] KIND_BLE    = 8'h08;
  localparam logic [7:0] MASK_UP     = 8'h30;
  localparam logic [7:0] MASK_BLE    = 8'h20;

  typedef struct packed {
    logic       data_valid;
    logic [7:0] data_byte;
    logic       data_last;
    logic       link_online;
    logic       link_ble;
    logic       ack_valid;
    logic [7:0] ack_command;
    logic [7:0] ack_result;
  } evdf_res_t;

endpackage
`default_nettype wire

/* design/evdf_if.sv */
// Channel interfaces: received byte requests in, deframed results out.
`default_nettype none
interface evdf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface evdf_out_if;
  logic       valid;
  logic       ready;
  logic       data_valid;
  logic [7:0] data_byte;
  logic       data_last;
  logic       link_online;
  logic       link_ble;
  logic       ack_valid;
  logic [7:0] ack_command;
  logic [7:0] ack_result;
  modport source (output valid, output data_valid, output data_byte, output data_last,
                  output link_online, output link_ble, output ack_valid,
                  output ack_command, output ack_result, input ready);
  modport sink   (input valid, input data_valid, input data_byte, input data_last,
                  input link_online, input link_ble, input ack_valid,
                  input ack_command, input ack_result, output ready);
endinterface
`default_nettype wire

/* design/module_event_deframer_link_tracker.sv */
// Top level: input register, frame parser, result buffer.
//
//   channel   dir   payload                                   flow control
//   in_if     in    rx_byte                                   valid / ready
//   out_if    out   data_*, link_online, link_ble, ack_*      valid / ready
//
// One request per cycle sustained while the result buffer has space; a result passes through the input
// register and then the result buffer before it is valid on the output.
// The parser state advances only when the registered byte moves into the result buffer.
// Reset clears the parser to hunting, the link to offline SPP and the ack fields to zero.
// Two results can wait on a stalled output while one more byte sits in the input register.
`default_nettype none
module module_event_deframer_link_tracker (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  evdf_in_if.sink     in_if,
  evdf_out_if.source  out_if
);
  import evdf_pkg::*;

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       space;
  logic       adv;
  evdf_res_t  res;

  assign adv         = in_valid_q && space;
  assign in_if.ready = !in_valid_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_if.ready) begin
      in_valid_q <= in_if.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_if.valid && in_if.ready) in_byte_q <= in_if.rx_byte;
  end

  evdf_parse u_parse (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .byte_i (in_byte_q),
    .res_o  (res)
  );

  evdf_outbuf u_outbuf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (adv),
    .res_i   (res),
    .space_o (space),
    .out_if  (out_if)
  );

endmodule
`default_nettype wire

/* design/evdf_parse.sv */
// Frame parser and link state: one byte per advance, result formed combinationally.
`default_nettype none
module evdf_parse (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              adv_i,
  input  wire logic [7:0]        byte_i,
  output evdf_pkg::evdf_res_t    res_o
);
  import evdf_pkg::*;

  evdf_phase_e phase_q, phase_d;
  logic [7:0]  kind_q, kind_d;
  logic [7:0]  len_q, len_d;
  logic [7:0]  pos_q, pos_d;
  logic [7:0]  pend_q, pend_d;
  logic        online_q, online_d;
  logic        ble_q, ble_d;
  logic [7:0]  ackc_q, ackc_d;
  logic [7:0]  ackr_q, ackr_d;
  logic        last;
  logic        dv, dl, av;

  assign last = ({1'b0, pos_q} + 9'd1) >= {1'b0, len_q};

  always_comb begin
    phase_d  = phase_q;
    kind_d   = kind_q;
    len_d    = len_q;
    pos_d    = pos_q;
    pend_d   = pend_q;
    online_d = online_q;
    ble_d    = ble_q;
    ackc_d   = ackc_q;
    ackr_d   = ackr_q;
    dv       = 1'b0;
    dl       = 1'b0;
    av       = 1'b0;
    case (phase_q)
      PH_HUNT: begin
        if (byte_i == START_BYTE) phase_d = PH_TYPE;
      end
      PH_TYPE: begin
        kind_d  = byte_i;
        phase_d = PH_LEN;
      end
      PH_LEN: begin
        len_d = byte_i;
        pos_d = '0;
        if (kind_q == KIND_SPP || kind_q == KIND_ONLINE) begin
          online_d = 1'b1;
          ble_d    = 1'b0;
        end else if (kind_q == KIND_BLE) begin
          online_d = 1'b1;
          ble_d    = 1'b1;
        end else if (kind_q == KIND_OFF_A || kind_q == KIND_OFF_B) begin
          online_d = 1'b0;
        end
        phase_d = (byte_i == 8'd0) ? PH_HUNT : PH_BODY;
      end
      PH_BODY: begin
        if (kind_q == KIND_SPP) begin
          dv = 1'b1;
          dl = last;
        end else if (kind_q == KIND_BLE) begin
          // drop the two handle bytes
          if (pos_q >= 8'd2) begin
            dv = 1'b1;
            dl = last;
          end
        end else if (kind_q == KIND_ACK) begin
          if (pos_q == 8'd0) begin
            pend_d = byte_i;
          end else if (pos_q == 8'd1) begin
            ackc_d = pend_q;
            ackr_d = byte_i;
            av     = 1'b1;
          end
        end else if (kind_q == KIND_STATUS) begin
          if (pos_q == 8'd0) begin
            if ((byte_i & MASK_UP) != 8'd0) begin
              online_d = 1'b1;
              ble_d    = (byte_i & MASK_BLE) != 8'd0;
            end else begin
              online_d = 1'b0;
            end
          end
        end
        if (last) begin
          phase_d = PH_HUNT;
          pos_d   = '0;
        end else begin
          pos_d = pos_q + 8'd1;
        end
      end
      default: phase_d = PH_HUNT;
    endcase
  end

  always_comb begin
    res_o.data_valid  = dv;
    res_o.data_byte   = dv ? byte_i : 8'd0;
    res_o.data_last   = dl;
    res_o.link_online = online_d;
    res_o.link_ble    = ble_d;
    res_o.ack_valid   = av;
    res_o.ack_command = ackc_d;
    res_o.ack_result  = ackr_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HUNT;
      kind_q   <= '0;
      len_q    <= '0;
      pos_q    <= '0;
      pend_q   <= '0;
      online_q <= 1'b0;
      ble_q    <= 1'b0;
      ackc_q   <= '0;
      ackr_q   <= '0;
    end else if (adv_i) begin
      phase_q  <= phase_d;
      kind_q   <= kind_d;
      len_q    <= len_d;
      pos_q    <= pos_d;
      pend_q   <= pend_d;
      online_q <= online_d;
      ble_q    <= ble_d;
      ackc_q   <= ackc_d;
      ackr_q   <= ackr_d;
    end
  end

endmodule
`default_nettype wire

/* design/evdf_outbuf.sv */
// Two-entry result buffer that drives the output channel.
`default_nettype none
module evdf_outbuf (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                wr_i,
  input  wire evdf_pkg::evdf_res_t res_i,
  output logic                     space_o,
  evdf_out_if.source               out_if
);
  import evdf_pkg::*;

  evdf_res_t  mem_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q, cnt_d;
  logic       rd;
  evdf_res_t  head;

  assign space_o = (cnt_q != 2'd2);
  assign rd      = out_if.valid && out_if.ready;
  assign head    = mem_q[rptr_q];

  always_comb begin
    cnt_d = cnt_q;
    case ({wr_i, rd})
      2'b10:   cnt_d = cnt_q + 2'd1;
      2'b01:   cnt_d = cnt_q - 2'd1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (wr_i) wptr_q <= ~wptr_q;
      if (rd)   rptr_q <= ~rptr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) mem_q[wptr_q] <= res_i;
  end

  assign out_if.valid       = (cnt_q != 2'd0);
  assign out_if.data_valid  = head.data_valid;
  assign out_if.data_byte   = head.data_byte;
  assign out_if.data_last   = head.data_last;
  assign out_if.link_online = head.link_online;
  assign out_if.link_ble    = head.link_ble;
  assign out_if.ack_valid   = head.ack_valid;
  assign out_if.ack_command = head.ack_command;
  assign out_if.ack_result  = head.ack_result;

endmodule
`default_nettype wire

/* design/evdf_checker.sv */
// Port-level checks for the deframer, bound to the top level.
`default_nettype none
module evdf_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_i,
  input wire logic       out_ready_i,
  input wire logic       data_valid_i,
  input wire logic [7:0] data_byte_i,
  input wire logic       data_last_i,
  input wire logic       ack_valid_i
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  a_last_needs_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && data_last_i |-> data_valid_i)
    else $error("data_last without data_valid");

  a_data_xor_ack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !(data_valid_i && ack_valid_i))
    else $error("data byte and ack in one result");

  a_idle_byte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !data_valid_i |-> data_byte_i == 8'd0)
    else $error("data_byte nonzero without data_valid");

endmodule

bind module_event_deframer_link_tracker evdf_checker u_evdf_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (out_if.valid),
  .out_ready_i  (out_if.ready),
  .data_valid_i (out_if.data_valid),
  .data_byte_i  (out_if.data_byte),
  .data_last_i  (out_if.data_last),
  .ack_valid_i  (out_if.ack_valid)
);
`default_nettype wire
